@@ design/cau_pkg.sv @@
// Package for the complex arithmetic unit: operation codes, status codes and
// default widths. Depends on nothing; all files but cau_if.sv import it.
package cau_pkg;

  localparam int DataWidthDef = 16;
  localparam int FracBitsDef  = 12;
  localparam int QueueDepth   = 2;

  typedef enum logic [2:0] {
    MODE_ADD = 3'd0,
    MODE_SUB = 3'd1,
    MODE_MUL = 3'd2,
    MODE_DIV = 3'd3,
    MODE_NEG = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_OVF  = 2'd1,
    STAT_DIV0 = 2'd2
  } status_e;

  // Handshake state of the queue as seen by its two neighbors.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

@@ design/cau_if.sv @@
// Request and response channel interfaces of the complex arithmetic unit.
// Depends on nothing but the widths handed in as parameters.
interface cau_req_if #(parameter int DW = 16);
  logic          valid;
  logic          ready;
  logic [2:0]    mode;
  logic [DW-1:0] a_real;
  logic [DW-1:0] a_imag;
  logic [DW-1:0] b_real;
  logic [DW-1:0] b_imag;
  modport source (output valid, mode, a_real, a_imag, b_real, b_imag, input ready);
  modport sink   (input valid, mode, a_real, a_imag, b_real, b_imag, output ready);
endinterface

interface cau_rsp_if #(parameter int DW = 16);
  logic          valid;
  logic          ready;
  logic [DW-1:0] r_real;
  logic [DW-1:0] r_imag;
  logic [1:0]    status;
  modport source (output valid, r_real, r_imag, status, input ready);
  modport sink   (input valid, r_real, r_imag, status, output ready);
endinterface

@@ design/cau_front.sv @@
// Front end: accepts requests, forms the partial products, sums and the divisor
// norm, and packs them into a queue entry. Depends on cau_pkg.
module cau_front import cau_pkg::*; #(
  parameter int DW = DataWidthDef,
  parameter int EW = 3 + 4 * (2 * DW) + (2 * DW + 1) + 2 * (DW + 1)
) (
  input  logic          valid_i,
  output logic          ready_i_o,
  input  logic [2:0]    mode_i,
  input  logic [DW-1:0] a_real_i,
  input  logic [DW-1:0] a_imag_i,
  input  logic [DW-1:0] b_real_i,
  input  logic [DW-1:0] b_imag_i,
  input  queue_stat_t   qstat_i,
  output logic          push_o,
  output logic [EW-1:0] entry_o
);
  localparam int PW = 2 * DW;

  logic signed [DW-1:0] ar, ai, br, bi;
  logic signed [PW-1:0] p_rr, p_ii, p_ir, p_ri, p_bb_r, p_bb_i;
  logic        [PW:0]   den;
  logic signed [DW:0]   s_re, s_im;

  assign ar = $signed(a_real_i);
  assign ai = $signed(a_imag_i);
  assign br = $signed(b_real_i);
  assign bi = $signed(b_imag_i);

  assign p_rr   = PW'(ar) * PW'(br);
  assign p_ii   = PW'(ai) * PW'(bi);
  assign p_ir   = PW'(ai) * PW'(br);
  assign p_ri   = PW'(ar) * PW'(bi);
  assign p_bb_r = PW'(br) * PW'(br);
  assign p_bb_i = PW'(bi) * PW'(bi);
  // Both squares are non-negative, so the norm is an unsigned sum.
  assign den    = {1'b0, p_bb_r} + {1'b0, p_bb_i};

  always_comb begin
    s_re = '0;
    s_im = '0;
    case (mode_i)
      MODE_ADD: begin
        s_re = (DW+1)'(ar) + (DW+1)'(br);
        s_im = (DW+1)'(ai) + (DW+1)'(bi);
      end
      MODE_SUB: begin
        s_re = (DW+1)'(ar) - (DW+1)'(br);
        s_im = (DW+1)'(ai) - (DW+1)'(bi);
      end
      MODE_NEG: begin
        s_re = -(DW+1)'(ar);
        s_im = -(DW+1)'(ai);
      end
      default: begin
        s_re = '0;
        s_im = '0;
      end
    endcase
  end

  assign ready_i_o = !qstat_i.full;
  assign push_o    = valid_i && !qstat_i.full;
  assign entry_o   = {mode_i, p_rr, p_ii, p_ir, p_ri, den, s_re, s_im};
endmodule

@@ design/cau_queue.sv @@
// Two-entry queue between the front and back ends.
// Depends on cau_pkg for the queue depth and status struct.
module cau_queue import cau_pkg::*; #(
  parameter int EW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [EW-1:0] wdata_i,
  input  logic          pop_i,
  output logic [EW-1:0] rdata_o,
  output queue_stat_t   qstat_o
);
  localparam int AW = $clog2(QueueDepth);

  logic [EW-1:0] mem_q [QueueDepth];
  logic [AW-1:0] wptr_q, rptr_q;
  logic [AW:0]   cnt_q;

  assign qstat_o.full  = (cnt_q == (AW+1)'(QueueDepth));
  assign qstat_o.empty = (cnt_q == '0);
  assign rdata_o       = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end
endmodule

@@ design/cau_back.sv @@
// Back end: finishes add, subtract, multiply and negate without the divider, runs
// division one quotient bit per cycle, saturates and holds the response.
// Depends on cau_pkg.
module cau_back import cau_pkg::*; #(
  parameter int DW = DataWidthDef,
  parameter int FB = FracBitsDef,
  parameter int EW = 3 + 4 * (2 * DW) + (2 * DW + 1) + 2 * (DW + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [EW-1:0] entry_i,
  input  queue_stat_t   qstat_i,
  output logic          pop_o,
  output logic          valid_o,
  input  logic          ready_i,
  output logic [DW-1:0] r_real_o,
  output logic [DW-1:0] r_imag_o,
  output logic [1:0]    status_o
);
  localparam int PW = 2 * DW;
  localparam int MW = PW + 1;
  localparam int QW = DW + 2;
  localparam int WW = 3 * DW + FB + 2;
  localparam int CW = $clog2(DW + 2);

  logic [2:0]           e_mode;
  logic signed [PW-1:0] p_rr, p_ii, p_ir, p_ri;
  logic        [PW:0]   e_den;
  logic signed [DW:0]   s_re, s_im;

  assign {e_mode, p_rr, p_ii, p_ir, p_ri, e_den, s_re, s_im} = entry_i;

  function automatic logic [MW-1:0] abs_f(input logic signed [MW-1:0] v);
    abs_f = v[MW-1] ? MW'(-v) : MW'(v);
  endfunction

  // Returns the overflow flag above the clamped bit pattern.
  function automatic logic [DW:0] sat_f(input logic neg, input logic [MW-1:0] mag);
    logic [MW-1:0] half;
    half = MW'(1) << (DW - 1);
    if (mag == '0) begin
      sat_f = '0;
    end else if (neg) begin
      if (mag > half) sat_f = {1'b1, half[DW-1:0]};
      else            sat_f = {1'b0, DW'(-mag)};
    end else begin
      if (mag > half - MW'(1)) sat_f = {1'b1, DW'(half - MW'(1))};
      else                     sat_f = {1'b0, mag[DW-1:0]};
    end
  endfunction

  // Divider state.
  logic          busy_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [WW-1:0] rem_re_q, rem_im_q, den_q;
  logic [QW-1:0] q_re_q, q_im_q;
  logic          neg_re_q, neg_im_q, big_re_q, big_im_q;

  // Output register.
  logic          ovalid_q;
  logic [DW-1:0] ore_q, oim_q;
  logic [1:0]    ost_q;

  logic out_free;
  assign out_free = !ovalid_q || ready_i;
  assign pop_o    = !qstat_i.empty && !busy_q && out_free;

  // Combinational results and the divide start.
  logic signed [MW-1:0] mul_re, mul_im, num_re, num_im;
  logic [MW-1:0]        fm_re, fm_im;
  logic                 fn_re, fn_im;
  logic [DW:0]          fs_re, fs_im;
  logic [1:0]           f_st;
  logic                 start_div;

  assign mul_re = MW'(p_rr) - MW'(p_ii);
  assign mul_im = MW'(p_ir) + MW'(p_ri);
  assign num_re = MW'(p_rr) + MW'(p_ii);
  assign num_im = MW'(p_ir) - MW'(p_ri);
  assign start_div = (e_mode == MODE_DIV) && (e_den != '0);

  always_comb begin
    fm_re = '0;
    fm_im = '0;
    fn_re = 1'b0;
    fn_im = 1'b0;
    f_st  = STAT_OK;
    case (e_mode)
      MODE_ADD, MODE_SUB, MODE_NEG: begin
        fn_re = s_re[DW];
        fn_im = s_im[DW];
        fm_re = abs_f(MW'(s_re));
        fm_im = abs_f(MW'(s_im));
      end
      MODE_MUL: begin
        fn_re = mul_re[MW-1];
        fn_im = mul_im[MW-1];
        fm_re = abs_f(mul_re) >> FB;
        fm_im = abs_f(mul_im) >> FB;
      end
      MODE_DIV: begin
        f_st = STAT_DIV0;
      end
      default: begin
        f_st = STAT_OK;
      end
    endcase
  end

  assign fs_re = sat_f(fn_re, fm_re);
  assign fs_im = sat_f(fn_im, fm_im);

  // Division step: compare the remainder against the shifted divisor.
  logic [WW-1:0] dsh, nrem_re, nrem_im, load_re, load_im, lim;
  logic          ge_re, ge_im;
  assign dsh   = den_q << cnt_q;
  assign ge_re = rem_re_q >= dsh;
  assign ge_im = rem_im_q >= dsh;
  assign nrem_re = ge_re ? rem_re_q - dsh : rem_re_q;
  assign nrem_im = ge_im ? rem_im_q - dsh : rem_im_q;
  assign load_re = WW'(abs_f(num_re)) << FB;
  assign load_im = WW'(abs_f(num_im)) << FB;
  assign lim     = WW'(e_den) << (DW + 1);

  logic [MW-1:0] dm_re, dm_im;
  logic [DW:0]   ds_re, ds_im;
  assign dm_re = big_re_q ? MW'(1) << (DW + 1) : MW'(q_re_q);
  assign dm_im = big_im_q ? MW'(1) << (DW + 1) : MW'(q_im_q);
  assign ds_re = sat_f(neg_re_q, dm_re);
  assign ds_im = sat_f(neg_im_q, dm_im);

  always_ff @(posedge clk_i) begin
    if (pop_o && start_div) begin
      rem_re_q <= load_re;
      rem_im_q <= load_im;
      den_q    <= WW'(e_den);
      neg_re_q <= num_re[MW-1];
      neg_im_q <= num_im[MW-1];
      big_re_q <= load_re >= lim;
      big_im_q <= load_im >= lim;
      q_re_q   <= '0;
      q_im_q   <= '0;
    end else if (busy_q && !done_q) begin
      rem_re_q <= nrem_re;
      rem_im_q <= nrem_im;
      q_re_q   <= {q_re_q[QW-2:0], ge_re};
      q_im_q   <= {q_im_q[QW-2:0], ge_im};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (pop_o && start_div) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CW'(DW);
    end else if (busy_q && !done_q) begin
      if (cnt_q == '0) begin
        done_q <= 1'b1;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end else if (done_q && out_free) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && !start_div) begin
      ore_q <= fs_re[DW-1:0];
      oim_q <= fs_im[DW-1:0];
      ost_q <= (fs_re[DW] || fs_im[DW]) ? STAT_OVF : f_st;
    end else if (done_q && out_free) begin
      ore_q <= ds_re[DW-1:0];
      oim_q <= ds_im[DW-1:0];
      ost_q <= (ds_re[DW] || ds_im[DW]) ? STAT_OVF : STAT_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if ((pop_o && !start_div) || (done_q && out_free)) begin
      ovalid_q <= 1'b1;
    end else if (ready_i) begin
      ovalid_q <= 1'b0;
    end
  end

  assign valid_o  = ovalid_q;
  assign r_real_o = ore_q;
  assign r_imag_o = oim_q;
  assign status_o = ost_q;
endmodule

@@ design/complex_arith_unit.sv @@
// Complex arithmetic unit on signed fixed point operands.
// Request channel (req): mode and operands a, b. Response channel (rsp):
// r_real, r_imag and status, all under valid/ready; a request or response is
// taken at a clock edge where valid and ready are both high.
// The front end forms all partial products as a request is taken and writes
// them into a two-entry queue; the back end finishes the operation and holds
// the response in an output register.
// Add, subtract, multiply, negate and the unused modes: a request passes
// through the queue and the output register, one request per cycle sustained
// while every response is taken and no divide occupies the back end.
// Divide: the back end's restoring divider yields DATA_WIDTH+1 quotient bits,
// one per cycle, and the back end takes no new request until the quotient is
// written to the output register. A zero divisor skips the divider and gives
// zero results and a divide-by-zero status.
// Reset empties the queue and the output register; no request is lost once
// taken. If the receiver stalls, the response stays put, the queue fills and
// then req.ready drops until room frees up.
// Depends on cau_pkg, the channel interfaces and the three submodules.
module complex_arith_unit import cau_pkg::*; #(
  parameter int DATA_WIDTH = DataWidthDef,
  parameter int FRAC_BITS  = FracBitsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  cau_req_if.sink    req,
  cau_rsp_if.source  rsp
);
  // Entry: mode, four cross products, divisor norm, two short sums.
  localparam int EW = 3 + 4 * (2 * DATA_WIDTH) + (2 * DATA_WIDTH + 1) + 2 * (DATA_WIDTH + 1);

  logic          push, pop;
  logic [EW-1:0] wentry, rentry;
  queue_stat_t   qstat;

  cau_front #(.DW(DATA_WIDTH), .EW(EW)) u_front (
    .valid_i   (req.valid),
    .ready_i_o (req.ready),
    .mode_i    (req.mode),
    .a_real_i  (req.a_real),
    .a_imag_i  (req.a_imag),
    .b_real_i  (req.b_real),
    .b_imag_i  (req.b_imag),
    .qstat_i   (qstat),
    .push_o    (push),
    .entry_o   (wentry)
  );

  cau_queue #(.EW(EW)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (wentry),
    .pop_i   (pop),
    .rdata_o (rentry),
    .qstat_o (qstat)
  );

  cau_back #(.DW(DATA_WIDTH), .FB(FRAC_BITS), .EW(EW)) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .entry_i  (rentry),
    .qstat_i  (qstat),
    .pop_o    (pop),
    .valid_o  (rsp.valid),
    .ready_i  (rsp.ready),
    .r_real_o (rsp.r_real),
    .r_imag_o (rsp.r_imag),
    .status_o (rsp.status)
  );
endmodule

@@ design/cau_checker.sv @@
// Port-level checks on the response channel of the complex arithmetic unit,
// bound to the top level. Depends on cau_pkg for the status codes.
module cau_checker import cau_pkg::*; #(
  parameter int DW = DataWidthDef
) (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          rsp_valid_i,
  input logic          rsp_ready_i,
  input logic [DW-1:0] r_real_i,
  input logic [DW-1:0] r_imag_i,
  input logic [1:0]    status_i
);
  // A divide by zero carries zero results.
  a_div0_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && status_i == STAT_DIV0) |-> (r_real_i == '0 && r_imag_i == '0))
    else $error("divide-by-zero response with nonzero result");

  // Status never takes the unused code.
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (status_i == STAT_OK || status_i == STAT_OVF || status_i == STAT_DIV0))
    else $error("unused status code");

  // A stalled response stays valid.
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_ready_i) |=> rsp_valid_i)
    else $error("response dropped while stalled");

  // A stalled response keeps its payload.
  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_ready_i) |=>
      ($stable(r_real_i) && $stable(r_imag_i) && $stable(status_i)))
    else $error("response payload changed while stalled");
endmodule

bind complex_arith_unit cau_checker #(.DW(DATA_WIDTH)) u_cau_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .rsp_valid_i (rsp.valid),
  .rsp_ready_i (rsp.ready),
  .r_real_i    (rsp.r_real),
  .r_imag_i    (rsp.r_imag),
  .status_i    (rsp.status)
);
